>>> sv/lssc_pkg.sv
// Package of shared types and constants for the Lyapunov safety stop check unit.
`default_nettype none

package lssc_pkg;

    // Entries of the symmetric weight matrix, signed with 24 fraction bits.
    localparam int COEF_W = 30;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef P_MAT [0:3][0:3] = '{
        '{ 30'sd427208918, -30'sd1922642,   30'sd71959733, -30'sd339140  },
        '{ -30'sd1922642,   30'sd49211284, -30'sd1846689,   30'sd4410946 },
        '{ 30'sd71959733,  -30'sd1846689,   30'sd96694841, -30'sd37221   },
        '{ -30'sd339140,    30'sd4410946,  -30'sd37221,     30'sd3397782 }
    };

    // Pipeline depth from acceptance to a registered potential: four lane stages
    // followed by two merge stages.
    localparam int LANE_LAT = 4;
    localparam int MERGE_LAT = 2;
    localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

    // Stop reason codes.
    typedef logic [1:0] t_reason;
    localparam t_reason REASON_CONTINUE = 2'd0;
    localparam t_reason REASON_SAFE     = 2'd1;
    localparam t_reason REASON_TIMEOUT  = 2'd2;
    localparam t_reason REASON_VIOLATE  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SAFETY_EN   = 3'd0;
    localparam t_cfg_idx CFG_POT_LIMIT   = 3'd1;
    localparam t_cfg_idx CFG_TIME_LIMIT  = 3'd2;
    localparam t_cfg_idx CFG_ELEV_FLOOR  = 3'd3;
    localparam t_cfg_idx CFG_MARGIN      = 3'd4;
    localparam t_cfg_idx CFG_PITCH_COUPL = 3'd5;

    // Decision inputs that travel beside the arithmetic pipeline.
    typedef struct packed {
        logic [15:0] sim_time;
        logic        time_hit;
        logic        violation;
    } t_side;

endpackage

`default_nettype wire

>>> sv/lssc_lane.sv
// One lane: row product of the weight matrix and the state, then weighted by its own state element.
`default_nettype none

module lssc_lane #(
    parameter int STATE_BITS = 16,
    parameter int LANE = 0
) (
    input  wire logic                             i_clk,
    input  wire logic signed [STATE_BITS-1:0]     i_x [4],
    output logic signed [2*STATE_BITS+31:0]       o_prod
);

    localparam int SB = STATE_BITS;
    localparam int PW = SB + lssc_pkg::COEF_W;   // one coefficient product
    localparam int YW = SB + 32;                  // row sum
    localparam int LW = 2 * SB + 32;              // lane result

    logic signed [PW-1:0]   r_pa [4];
    logic signed [SB-1:0]   r_xa;
    logic signed [YW-1:0]   r_y;
    logic signed [SB-1:0]   r_xb;
    logic signed [SB+32:0]  r_lo;
    logic signed [2*SB-1:0] r_hi;
    logic signed [LW-1:0]   r_prod;

    // Stage one: the four coefficient products of this row.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_pa[j] <= PW'(lssc_pkg::P_MAT[LANE][j]) * PW'(i_x[j]);
        end
        r_xa <= i_x[LANE];
    end

    // Stage two: the row sum.
    always_ff @(posedge i_clk) begin
        r_y  <= YW'(r_pa[0]) + YW'(r_pa[1]) + YW'(r_pa[2]) + YW'(r_pa[3]);
        r_xb <= r_xa;
    end

    // Stage three: the row sum is split into a low unsigned word and a signed
    // upper part so that each multiplier stays narrow.
    always_ff @(posedge i_clk) begin
        r_lo <= (SB+33)'(r_xb) * (SB+33)'($signed({1'b0, r_y[31:0]}));
        r_hi <= (2*SB)'(r_xb) * (2*SB)'($signed(r_y[YW-1:32]));
    end

    // Stage four: recombine the partial products.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed({r_hi, 32'b0}) + LW'(r_lo);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> sv/lssc_merge.sv
// Merging stage: sums the lane results, rescales to Q16.16, clamps and saturates.
`default_nettype none

module lssc_merge #(
    parameter int STATE_BITS = 16,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic signed [2*STATE_BITS+31:0] i_prod [4],
    output logic [31:0]                        o_potential
);

    localparam int LW = 2 * STATE_BITS + 32;
    localparam int AW = LW + 2;
    localparam int SHIFT = 2 * FRAC_BITS + 8;

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] w_scaled;
    logic [31:0]          r_pot;

    always_ff @(posedge i_clk) begin
        r_acc <= AW'(i_prod[0]) + AW'(i_prod[1]) + AW'(i_prod[2]) + AW'(i_prod[3]);
    end

    assign w_scaled = r_acc >>> SHIFT;

    // A negative sum reads as zero; anything above 32 bits saturates.
    always_ff @(posedge i_clk) begin
        if (r_acc[AW-1]) begin
            r_pot <= 32'd0;
        end else if (|w_scaled[AW-1:32]) begin
            r_pot <= 32'hFFFF_FFFF;
        end else begin
            r_pot <= w_scaled[31:0];
        end
    end

    assign o_potential = r_pot;

endmodule

`default_nettype wire

>>> sv/lyapunov_safety_stop_check_unit.sv
// Top level of the Lyapunov safety stop check: configuration, constraint tests, lanes and decision.
//
//  Channel   | Direction | Handshake               | Payload
//  ----------+-----------+-------------------------+-----------------------------------------
//  sample    | in        | i_start while !o_busy   | i_elevation, i_pitch, i_elevation_rate,
//            |           |                         | i_pitch_rate, i_sim_time
//  result    | out       | o_valid, one cycle each | o_stop, o_stop_time, o_stop_reason,
//            |           |                         | o_potential_value
//  config    | in        | i_cfg_we                | i_cfg_idx, i_cfg_wdata
//
// A new sample transaction may be accepted in every clock cycle; o_busy is never raised.
// Each accepted sample passes four stages in the lanes (coefficient products, row sum, split
// multiply, recombine), two in the merging stage (lane sum, rescale and saturate) and one for
// the stop decision.
// Reset is synchronous and active low; it clears the result strobe, the pipeline valid bits
// and returns every configuration register to its documented reset value.
// The receiver cannot stall, so results are never held back and nothing is buffered.
`default_nettype none

module lyapunov_safety_stop_check_unit #(
    parameter int STATE_BITS = 16,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Sample channel
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic signed [STATE_BITS-1:0]  i_elevation,
    input  wire logic signed [STATE_BITS-1:0]  i_pitch,
    input  wire logic signed [STATE_BITS-1:0]  i_elevation_rate,
    input  wire logic signed [STATE_BITS-1:0]  i_pitch_rate,
    input  wire logic [15:0]                   i_sim_time,
    // Configuration port
    input  wire logic                          i_cfg_we,
    input  wire logic [lssc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_wdata,
    // Result channel
    output logic                               o_valid,
    output logic                               o_stop,
    output logic signed [16:0]                 o_stop_time,
    output logic [1:0]                         o_stop_reason,
    output logic [31:0]                        o_potential_value
);

    localparam int SB = STATE_BITS;
    localparam int LW = 2 * SB + 32;
    // Width that holds both sides of the constraint tests exactly.
    localparam int CW = SB + FRAC_BITS + 20;
    localparam int LAT = lssc_pkg::PIPE_LAT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               r_safety_en;
    logic [31:0]        r_pot_limit;
    logic [15:0]        r_time_limit;
    logic signed [15:0] r_elev_floor;
    logic [14:0]        r_margin;
    logic [11:0]        r_pitch_coupl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_en   <= 1'b1;
            r_pot_limit   <= 32'd65536;
            r_time_limit  <= 16'd10000;
            r_elev_floor  <= -16'sd1638;
            r_margin      <= 15'd1229;
            r_pitch_coupl <= 12'd1365;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lssc_pkg::CFG_SAFETY_EN:   r_safety_en   <= i_cfg_wdata[0];
                lssc_pkg::CFG_POT_LIMIT:   r_pot_limit   <= i_cfg_wdata;
                lssc_pkg::CFG_TIME_LIMIT:  r_time_limit  <= i_cfg_wdata[15:0];
                lssc_pkg::CFG_ELEV_FLOOR:  r_elev_floor  <= $signed(i_cfg_wdata[15:0]);
                lssc_pkg::CFG_MARGIN:      r_margin      <= i_cfg_wdata[14:0];
                lssc_pkg::CFG_PITCH_COUPL: r_pitch_coupl <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Acceptance: the pipeline takes a sample every cycle.
    // ------------------------------------------------------------------
    logic w_accept;

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // ------------------------------------------------------------------
    // Constraint and time-limit tests, worked out on arrival. All terms are
    // brought to FRAC_BITS + 12 fraction bits, so the comparisons are exact.
    // ------------------------------------------------------------------
    logic [SB-1:0]        w_pitch_mag;
    logic [SB+11:0]       w_pitch_term;
    logic signed [CW-1:0] w_elev_scaled;
    logic signed [CW-1:0] w_lhs;
    logic signed [CW-1:0] w_rhs;
    logic signed [CW-1:0] w_floor_scaled;
    lssc_pkg::t_side      w_side;

    assign w_pitch_mag    = i_pitch[SB-1] ? SB'(-i_pitch) : SB'(i_pitch);
    assign w_pitch_term   = (SB+12)'(w_pitch_mag) * (SB+12)'(r_pitch_coupl);
    assign w_elev_scaled  = CW'(i_elevation) <<< 12;
    assign w_lhs          = $signed(CW'(w_pitch_term)) - w_elev_scaled;
    assign w_rhs          = $signed(CW'(r_margin)) <<< FRAC_BITS;
    assign w_floor_scaled = CW'(r_elev_floor) <<< FRAC_BITS;

    always_comb begin
        w_side.sim_time  = i_sim_time;
        w_side.time_hit  = (i_sim_time >= r_time_limit);
        w_side.violation = r_safety_en &
                           ((w_lhs >= w_rhs) | (w_elev_scaled < w_floor_scaled));
    end

    // Side information and valid bits travel alongside the arithmetic.
    lssc_pkg::t_side r_side [LAT];
    logic [LAT-1:0]  r_vld;

    always_ff @(posedge i_clk) begin
        r_side[0] <= w_side;
        for (int k = 1; k < LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // Four lanes, one per matrix row, and the merging stage.
    // ------------------------------------------------------------------
    logic signed [SB-1:0] w_x [4];
    logic signed [LW-1:0] w_prod [4];
    logic [31:0]          w_potential;

    assign w_x[0] = i_elevation;
    assign w_x[1] = i_pitch;
    assign w_x[2] = i_elevation_rate;
    assign w_x[3] = i_pitch_rate;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        lssc_lane #(
            .STATE_BITS (STATE_BITS),
            .LANE       (g)
        ) u_lane (
            .i_clk  (i_clk),
            .i_x    (w_x),
            .o_prod (w_prod[g])
        );
    end

    lssc_merge #(
        .STATE_BITS (STATE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_prod      (w_prod),
        .o_potential (w_potential)
    );

    // ------------------------------------------------------------------
    // Stop decision. A constraint violation outranks the time limit, which
    // outranks reaching the safe level.
    // ------------------------------------------------------------------
    lssc_pkg::t_side r_side_last;
    logic               n_stop;
    logic signed [16:0] n_stop_time;
    lssc_pkg::t_reason  n_reason;

    assign r_side_last = r_side[LAT-1];

    always_comb begin
        if (r_side_last.violation) begin
            n_stop      = 1'b1;
            n_stop_time = -17'sd1;
            n_reason    = lssc_pkg::REASON_VIOLATE;
        end else if (r_side_last.time_hit) begin
            n_stop      = 1'b1;
            n_stop_time = -17'sd1;
            n_reason    = lssc_pkg::REASON_TIMEOUT;
        end else if (w_potential < r_pot_limit) begin
            n_stop      = 1'b1;
            n_stop_time = $signed({1'b0, r_side_last.sim_time});
            n_reason    = lssc_pkg::REASON_SAFE;
        end else begin
            n_stop      = 1'b0;
            n_stop_time = 17'sd0;
            n_reason    = lssc_pkg::REASON_CONTINUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_stop            <= n_stop;
        o_stop_time       <= n_stop_time;
        o_stop_reason     <= n_reason;
        o_potential_value <= w_potential;
    end

endmodule

`default_nettype wire

>>> sv/lssc_checker.sv
// Port-level checker for the Lyapunov safety stop check unit, with its bind statement.
`default_nettype none

module lssc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic               o_valid,
    input wire logic               o_stop,
    input wire logic signed [16:0] o_stop_time,
    input wire logic [1:0]         o_stop_reason
);

    localparam int RESULT_LAT = lssc_pkg::PIPE_LAT + 1;

    // Every accepted sample transaction yields its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##RESULT_LAT o_valid)
        else $error("result missing after accepted sample");

    // The stop flag agrees with the reason code.
    a_stop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stop == (o_stop_reason != lssc_pkg::REASON_CONTINUE)))
        else $error("stop flag disagrees with reason");

    // Unsafe or timed-out stops report minus one.
    a_abort_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_stop_reason == lssc_pkg::REASON_TIMEOUT ||
                     o_stop_reason == lssc_pkg::REASON_VIOLATE))
        |-> (o_stop_time == -17'sd1))
        else $error("aborted stop without minus one");

    // Continuing samples report zero; safe stops report a non-negative time.
    a_cont_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_stop_reason == lssc_pkg::REASON_CONTINUE) ? (o_stop_time == 17'sd0)
                    : ((o_stop_reason != lssc_pkg::REASON_SAFE) || !o_stop_time[16])))
        else $error("stop time inconsistent with reason");

endmodule

bind lyapunov_safety_stop_check_unit lssc_checker u_lssc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_stop        (o_stop),
    .o_stop_time   (o_stop_time),
    .o_stop_reason (o_stop_reason)
);

`default_nettype wire
